@@ hw/rtl/sd_card_spi_mode_responder_defines.svh @@
// Assertion macros for the SD card SPI-mode responder.
// Used by the top level only; needs clk and rst in scope.
`ifndef SD_CARD_SPI_MODE_RESPONDER_DEFINES_SVH
`define SD_CARD_SPI_MODE_RESPONDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sdr_pkg.sv @@
// Shared types and constants for the SD card SPI-mode responder.
// No dependencies; imported by every module of the block.
`default_nettype none
package sdr_pkg;
  localparam int STORE_BYTES = 4194304;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int QUEUE_DEPTH = 1024;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = QUEUE_AW + 1;
  localparam int BLOCK_AW    = 9;
  localparam int ADDR_W      = 22;

  localparam logic [7:0] START_MASK    = 8'hc0;
  localparam logic [7:0] START_CODE    = 8'h40;
  localparam logic [7:0] R1_IDLE       = 8'h01;
  localparam logic [7:0] R1_READY      = 8'h00;
  localparam logic [7:0] R1_ILLEGAL    = 8'h04;
  localparam logic [7:0] R1_OP_PENDING = 8'h05;
  localparam logic [7:0] DATA_ACCEPTED = 8'h05;
  localparam logic [7:0] CHECK_PATTERN = 8'haa;
  localparam logic [7:0] OCR_HIGH      = 8'h40;
  localparam logic [7:0] DATA_TOKEN    = 8'hfe;
  localparam logic [7:0] IDLE_BYTE     = 8'hff;
  localparam logic [7:0] VOLTAGE_OK    = 8'h01;

  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_SD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP_CMD      = 6'd55;
  localparam logic [5:0] CMD_READ_OCR     = 6'd58;

  localparam logic [1:0] WP_IDLE  = 2'd0;
  localparam logic [1:0] WP_TOKEN = 2'd1;
  localparam logic [1:0] WP_DATA  = 2'd2;

  // Read burst: three header bytes, the block, two CRC bytes.
  localparam logic [9:0] BLK_FIRST_DATA = 10'd3;
  localparam logic [9:0] BLK_LAST_DATA  = 10'd514;
  localparam logic [9:0] BLK_LAST       = 10'd516;
  localparam logic [9:0] WR_BLOCK_END   = 10'd512;
  localparam logic [9:0] WR_LAST        = 10'd513;

  typedef struct packed {
    logic              preload;
    logic              chip_select_n;
    logic              serial_clock;
    logic              data_in;
    logic [ADDR_W-1:0] load_address;
    logic [7:0]        load_data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;
endpackage
`default_nettype wire

@@ hw/rtl/sdr_front.sv @@
// Front end: two-entry transaction queue that accepts and tags items.
// Depends on sdr_pkg.
`default_nettype none
module sdr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     cmd,
  input  logic                     chip_select_n,
  input  logic                     serial_clock,
  input  logic                     data_in,
  input  logic [21:0]              load_address,
  input  logic [7:0]               load_data,
  input  logic                     deq,
  output sdr_pkg::front_out_t      fo
);
  import sdr_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       take;
  logic       give;

  assign full = (fill == 2'd2);
  assign take = push && !full;
  assign give = deq && (fill != 2'd0);
  assign fo.valid = (fill != 2'd0);
  assign fo.item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (take) begin
      slot[wr_ptr] <= '{preload: cmd, chip_select_n: chip_select_n,
                        serial_clock: serial_clock, data_in: data_in,
                        load_address: load_address, load_data: load_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (take) wr_ptr <= ~wr_ptr;
      if (give) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(take) - 2'(give);
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sdr_engine.sv @@
// Back end: pin sampling, command decode, reply queue and card store.
// Depends on sdr_pkg.
`default_nettype none
module sdr_engine (
  input  logic                clk,
  input  logic                rst,
  input  sdr_pkg::front_out_t fo,
  output logic                deq,
  input  logic                res_ready,
  output logic                res_valid,
  output logic                res_data
);
  import sdr_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_BYTE  = 4'd3;
  localparam logic [3:0] S_PUSH  = 4'd4;
  localparam logic [3:0] S_BLKRD = 4'd5;
  localparam logic [3:0] S_BLKWR = 4'd6;
  localparam logic [3:0] S_POPW  = 4'd7;
  localparam logic [3:0] S_POPT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]          state;
  logic [STORE_AW-1:0] clr_addr;
  item_t               it;

  logic [7:0]          store [STORE_BYTES];
  logic [7:0]          st_rd;
  logic                st_we;
  logic [STORE_AW-1:0] st_wa;
  logic [7:0]          st_wd;
  logic [STORE_AW-1:0] st_ra;

  logic [7:0]          rq [QUEUE_DEPTH];
  logic [7:0]          q_rd;
  logic [QUEUE_AW-1:0] head;
  logic [QUEUE_AW-1:0] tail;
  logic [COUNT_W-1:0]  count;
  logic                push_en;
  logic                push_ok;
  logic [7:0]          push_val;
  logic                pop_do;

  logic [7:0]          cbuf [6];
  logic [2:0]          fill;
  logic                selected;
  logic                last_clk;
  logic [2:0]          bitpos;
  logic [7:0]          shift_in;
  logic [7:0]          shift_out;
  logic                out_level;
  logic                card_ready;
  logic                app_seen;
  logic [1:0]          wphase;
  logic [31:0]         wblock;
  logic [9:0]          wcount;
  logic [31:0]         rblock;
  logic [9:0]          bidx;
  logic                blk_in;
  logic [7:0]          byte_r;
  logic [7:0]          plist [5];
  logic [2:0]          plen;
  logic [2:0]          pidx;
  logic                res;

  logic                pin_item;
  logic [7:0]          pop_val;
  logic [7:0]          so;
  logic [2:0]          bp;
  logic [7:0]          si;
  logic [7:0]          si2;
  logic                ol2;
  logic                rise;
  logic                fall;
  logic                wr_in;
  logic                rd_in;
  logic [5:0]          cmd_idx;
  logic [7:0]          r1;
  logic                ready_after;
  logic [8:0]          blk_off;

  assign deq       = (state == S_IDLE) && fo.valid;
  assign res_valid = (state == S_DONE) && res_ready;
  assign res_data  = res;

  always_comb begin
    pin_item = !it.preload && !it.chip_select_n;
    pop_val  = (count == '0) ? IDLE_BYTE : q_rd;
    so       = selected ? shift_out : pop_val;
    bp       = selected ? bitpos : 3'd0;
    si       = selected ? shift_in : 8'd0;
    rise     = !last_clk && it.serial_clock;
    fall     = last_clk && !it.serial_clock;
    si2      = {si[6:0], it.data_in};
    ol2      = fall ? so[3'd7 - bp] : (selected ? out_level : so[7]);
    wr_in    = (wblock[31:STORE_AW-BLOCK_AW] == '0);
    rd_in    = (rblock[31:STORE_AW-BLOCK_AW] == '0);
    cmd_idx  = cbuf[0][5:0];
    r1       = card_ready ? R1_READY : R1_IDLE;
    ready_after = card_ready || app_seen;
    blk_off  = 9'(bidx - BLK_FIRST_DATA);
    tail     = head + count[QUEUE_AW-1:0];

    push_en  = 1'b0;
    push_val = IDLE_BYTE;
    unique case (state)
      S_PUSH: begin
        push_en  = 1'b1;
        push_val = plist[pidx];
      end
      S_BLKWR: begin
        push_en = 1'b1;
        if (bidx == 10'd0) push_val = R1_READY;
        else if (bidx == 10'd1) push_val = IDLE_BYTE;
        else if (bidx == 10'd2) push_val = DATA_TOKEN;
        else if (bidx > BLK_LAST_DATA) push_val = IDLE_BYTE;
        else push_val = blk_in ? st_rd : 8'd0;
      end
      S_BYTE: begin
        push_en  = (wphase == WP_DATA) && (wcount == WR_LAST);
        push_val = DATA_ACCEPTED;
      end
      default: ;
    endcase
    push_ok = push_en && (count < COUNT_W'(QUEUE_DEPTH));
    pop_do  = (count != '0) &&
              (((state == S_EXEC) && pin_item && !selected) || (state == S_POPT));

    st_we = 1'b0;
    st_wa = clr_addr;
    st_wd = 8'd0;
    unique case (state)
      S_CLEAR: st_we = 1'b1;
      S_EXEC: begin
        st_we = it.preload &&
                ({1'b0, it.load_address} < (ADDR_W+1)'(STORE_BYTES));
        st_wa = STORE_AW'(it.load_address);
        st_wd = it.load_data;
      end
      S_BYTE: begin
        st_we = (wphase == WP_DATA) && (wcount < WR_BLOCK_END) && wr_in;
        st_wa = {wblock[STORE_AW-BLOCK_AW-1:0], wcount[BLOCK_AW-1:0]};
        st_wd = byte_r;
      end
      default: ;
    endcase
    st_ra = {rblock[STORE_AW-BLOCK_AW-1:0], blk_off};
  end

  // Card store: one write port, registered read.
  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    st_rd <= store[st_ra];
  end

  // Reply queue: write at tail, head always read into q_rd.
  always_ff @(posedge clk) begin
    if (push_ok) rq[tail] <= push_val;
    q_rd <= rq[head];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) it <= fo.item;
    if (state == S_BLKRD) blk_in <= rd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      head       <= '0;
      count      <= '0;
      fill       <= 3'd0;
      selected   <= 1'b0;
      last_clk   <= 1'b0;
      bitpos     <= 3'd0;
      shift_in   <= 8'd0;
      shift_out  <= IDLE_BYTE;
      out_level  <= 1'b1;
      card_ready <= 1'b0;
      app_seen   <= 1'b0;
      wphase     <= WP_IDLE;
      wblock     <= 32'd0;
      wcount     <= 10'd0;
      rblock     <= 32'd0;
      bidx       <= 10'd0;
      plen       <= 3'd0;
      pidx       <= 3'd0;
      res        <= 1'b1;
    end else begin
      count <= count + COUNT_W'(push_ok) - COUNT_W'(pop_do);
      if (pop_do) head <= head + 1'b1;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == STORE_AW'(STORE_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (fo.valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          if (it.preload) begin
            res <= out_level;
          end else if (it.chip_select_n) begin
            selected  <= 1'b0;
            last_clk  <= it.serial_clock;
            out_level <= 1'b1;
            fill      <= 3'd0;
            res       <= 1'b1;
          end else begin
            selected  <= 1'b1;
            shift_out <= so;
            out_level <= ol2;
            res       <= ol2;
            last_clk  <= it.serial_clock;
            if (rise && bp == 3'd7) begin
              byte_r   <= si2;
              shift_in <= 8'd0;
              bitpos   <= 3'd0;
              state    <= S_BYTE;
            end else if (rise) begin
              shift_in <= si2;
              bitpos   <= bp + 3'd1;
            end else begin
              shift_in <= si;
              bitpos   <= bp;
            end
          end
        end
        S_BYTE: begin
          state <= S_POPW;
          pidx  <= 3'd0;
          if (wphase == WP_TOKEN) begin
            if (byte_r == DATA_TOKEN) begin
              wcount <= 10'd0;
              wphase <= WP_DATA;
            end
          end else if (wphase == WP_DATA) begin
            if (wcount == WR_LAST) begin
              wphase <= WP_IDLE;
              wcount <= 10'd0;
            end else begin
              wcount <= wcount + 10'd1;
            end
          end else if (wphase != WP_IDLE) begin
            wphase <= WP_IDLE;
          end else if (fill == 3'd0) begin
            if ((byte_r & START_MASK) == START_CODE) begin
              cbuf[0] <= byte_r;
              fill    <= 3'd1;
            end
          end else if (fill != 3'd5) begin
            cbuf[fill] <= byte_r;
            fill       <= fill + 3'd1;
          end else begin
            cbuf[5] <= byte_r;
            fill    <= 3'd0;
            state   <= S_PUSH;
            plen    <= 3'd1;
            unique case (cmd_idx)
              CMD_GO_IDLE: begin
                card_ready <= 1'b0;
                plist[0]   <= R1_IDLE;
              end
              CMD_SEND_IF_COND: begin
                plist[0] <= r1;
                plist[1] <= 8'd0;
                plist[2] <= 8'd0;
                plist[3] <= VOLTAGE_OK;
                plist[4] <= CHECK_PATTERN;
                plen     <= 3'd5;
              end
              CMD_SET_BLOCKLEN: plist[0] <= R1_READY;
              CMD_APP_CMD: begin
                app_seen <= 1'b1;
                plist[0] <= r1;
              end
              CMD_SD_OP_COND: begin
                card_ready <= ready_after;
                app_seen   <= 1'b0;
                plist[0]   <= ready_after ? R1_READY : R1_OP_PENDING;
              end
              CMD_READ_OCR: begin
                plist[0] <= r1;
                plist[1] <= OCR_HIGH;
                plist[2] <= 8'd0;
                plist[3] <= 8'd0;
                plist[4] <= 8'd0;
                plen     <= 3'd5;
              end
              CMD_READ_SINGLE: begin
                rblock <= {cbuf[1], cbuf[2], cbuf[3], cbuf[4]};
                bidx   <= 10'd0;
                state  <= S_BLKRD;
              end
              CMD_WRITE_SINGLE: begin
                wblock   <= {cbuf[1], cbuf[2], cbuf[3], cbuf[4]};
                wphase   <= WP_TOKEN;
                plist[0] <= R1_READY;
              end
              default: plist[0] <= R1_ILLEGAL;
            endcase
          end
        end
        S_PUSH: begin
          pidx <= pidx + 3'd1;
          if (pidx == plen - 3'd1) state <= S_POPW;
        end
        S_BLKRD: state <= S_BLKWR;
        S_BLKWR: begin
          bidx <= bidx + 10'd1;
          state <= (bidx == BLK_LAST) ? S_POPW : S_BLKRD;
        end
        S_POPW: state <= S_POPT;
        S_POPT: begin
          shift_out <= pop_val;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sd_card_spi_mode_responder.sv @@
// A pin sample or preload transaction passes back end states IDLE, EXEC and DONE;
// a completed byte adds BYTE, POPW and POPT, a short reply adds PUSH (one reply byte
// a cycle), a block read alternates BLKRD and BLKWR; the back end takes one at a time.
// Reset: synchronous; the 4194304-byte card store is cleared one byte a cycle,
// and no transaction is taken by the back end until that pass ends.
// Depends on sdr_pkg, sdr_front, sdr_engine and the assertion macro header.
`default_nettype none
module sd_card_spi_mode_responder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic        chip_select_n,
  input  logic        serial_clock,
  input  logic        data_in,
  input  logic [21:0] load_address,
  input  logic [7:0]  load_data,
  output logic        empty,
  input  logic        pop,
  output logic        data_out
);
  import sdr_pkg::*;

  front_out_t fo;
  logic       deq;
  logic       res_ready;
  logic       res_valid;
  logic       res_data;
  logic       out_valid;
  logic       out_data;

  // Front end: hold up to two transactions so the host is not held off
  // while the back end works through a command.
  sdr_front u_front (
    .clk, .rst, .push, .full, .cmd, .chip_select_n, .serial_clock,
    .data_in, .load_address, .load_data, .deq, .fo
  );

  // Back end: advance the SPI state, decode commands, fill the reply queue.
  sdr_engine u_engine (
    .clk, .rst, .fo, .deq, .res_ready, .res_valid, .res_data
  );

  // Output register: hold the data-out level until it is popped.
  assign res_ready = !out_valid || pop;
  assign empty     = !out_valid;
  assign data_out  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data <= res_data;
  end

`include "sd_card_spi_mode_responder_defines.svh"

  `SDR_ASSERT_NOW(a_result_has_room, res_valid, res_ready, "result with output register occupied")
  `SDR_ASSERT_NOW(a_deq_has_item, deq, fo.valid, "back end took from an empty front queue")
  `SDR_ASSERT_NEXT(a_pop_drains, pop && out_valid && !res_valid, empty, "popped result still shown")
endmodule
`default_nettype wire
